>>> src/aob_pkg.sv
// ----------------------------------------------------------------------------
// aob_pkg
// Shared constants and sine table generator for the oscillator bank.
// ----------------------------------------------------------------------------
package aob_pkg;

    localparam int ONE_Q15      = 32768;
    localparam int MIN_AMP_Q15  = 328;
    localparam int STRIDE_LIMIT = 128;
    localparam int ACTIVE_MAX   = 511;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam logic [1:0] MODE_MASK   = 2'd0;
    localparam logic [1:0] MODE_FRAME  = 2'd1;
    localparam logic [1:0] MODE_SAMPLE = 2'd2;

    localparam logic [1:0] CFG_SMOOTH    = 2'd0;
    localparam logic [1:0] CFG_DECAY     = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    function automatic longint quarter_sine(input longint r, input int qbits);
        longint th;
        longint t2;
        longint one;
        longint acc;
        one = 64'sd1 <<< 30;
        th  = (r * HALF_PI_Q30) >>> qbits;
        t2  = (th * th) >>> 30;
        acc = one - t2 / 110;
        acc = one - ((t2 * acc) >>> 30) / 72;
        acc = one - ((t2 * acc) >>> 30) / 42;
        acc = one - ((t2 * acc) >>> 30) / 20;
        acc = one - ((t2 * acc) >>> 30) / 6;
        acc = (th * acc) >>> 30;
        return (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [15:0] sine_entry(input int i, input int tbits);
        int     qbits;
        int     q;
        int     quad;
        int     r;
        longint v;
        qbits = tbits - 2;
        q     = 1 << qbits;
        quad  = i >> qbits;
        r     = i & (q - 1);
        case (quad)
            0:       v = quarter_sine(longint'(r), qbits);
            1:       v = quarter_sine(longint'(q - r), qbits);
            2:       v = -quarter_sine(longint'(r), qbits);
            default: v = -quarter_sine(longint'(q - r), qbits);
        endcase
        return 16'(v);
    endfunction

endpackage

>>> src/additive_oscillator_bank_core.sv
// ----------------------------------------------------------------------------
// additive_oscillator_bank_core
// Additive sine oscillator bank driven by a per-bin spectral mask.
// ----------------------------------------------------------------------------
// One shared 17x21 multiplier runs under a sequencer over three single-port
// bin memories. A mask transaction reads one bin and may raise its target. A
// frame transaction passes ST_F_RD, ST_F_M1, ST_F_M2 and ST_F_WR for each bin.
// A sample transaction passes ST_S_RD, ST_S_AMP and ST_S_CHK for each visited
// inner bin, plus ST_S_TERM and ST_S_ACC for each rendered bin. After reset a
// clearing pass zeroes the memories before the first transaction is taken;
// configuration writes are taken at any time. A finished result waits in an
// output register while the next transaction is accepted.
module additive_oscillator_bank_core
    import aob_pkg::*;
#(
    parameter int FFT_SIZE        = 1024,
    parameter int NUM_BINS        = 513,
    parameter int PHASE_BITS      = 24,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_addr,
    input  logic [15:0]        i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic [9:0]         i_bin_index,
    input  logic signed [16:0] i_mask_value,
    input  logic [15:0]        i_gain,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_result_kind,
    output logic signed [31:0] o_sample_value,
    output logic [8:0]         o_active_bins,
    output logic [1:0]         o_stride_used
);

    localparam int K_W      = $clog2(NUM_BINS);
    localparam int CNT_W    = $clog2(NUM_BINS);
    localparam int FFT_LOG  = $clog2(FFT_SIZE);
    localparam int SINE_LEN = 1 << SINE_TABLE_BITS;
    localparam int SUM_W    = 33 + $clog2(NUM_BINS);

    localparam logic [3:0] ST_CLR    = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_M_RD   = 4'd2;
    localparam logic [3:0] ST_M_WR   = 4'd3;
    localparam logic [3:0] ST_F_RD   = 4'd4;
    localparam logic [3:0] ST_F_M1   = 4'd5;
    localparam logic [3:0] ST_F_M2   = 4'd6;
    localparam logic [3:0] ST_F_WR   = 4'd7;
    localparam logic [3:0] ST_S_RD   = 4'd8;
    localparam logic [3:0] ST_S_AMP  = 4'd9;
    localparam logic [3:0] ST_S_CHK  = 4'd10;
    localparam logic [3:0] ST_S_TERM = 4'd11;
    localparam logic [3:0] ST_S_ACC  = 4'd12;
    localparam logic [3:0] ST_DONE   = 4'd13;

    logic [3:0]             r_state;
    logic [K_W-1:0]         r_k;
    logic [1:0]             r_mode;
    logic [15:0]            r_mask;
    logic [15:0]            r_gain;
    logic [15:0]            r_smooth;
    logic [15:0]            r_decay;
    logic [15:0]            r_thr;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       r_active;
    logic [1:0]             r_stride;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [37:0]     r_prod;
    logic signed [15:0]     r_sin;
    logic [18:0]            r_amp;
    logic                   r_out_valid;
    logic                   r_out_kind;
    logic signed [31:0]     r_out_sample;
    logic [8:0]             r_out_active;
    logic [1:0]             r_out_stride;

    logic [15:0]            mem_t [NUM_BINS];
    logic [15:0]            mem_s [NUM_BINS];
    logic [PHASE_BITS-1:0]  mem_p [NUM_BINS];
    logic [15:0]            r_t_rd;
    logic [15:0]            r_s_rd;
    logic [PHASE_BITS-1:0]  r_p_rd;

    logic                   w_t_we;
    logic                   w_s_we;
    logic                   w_p_we;
    logic [15:0]            w_t_wd;
    logic [15:0]            w_s_wd;
    logic [PHASE_BITS-1:0]  w_p_wd;

    logic signed [16:0]     w_mul_a;
    logic signed [20:0]     w_mul_b;
    logic signed [16:0]     w_diff;
    logic signed [18:0]     w_s1;
    logic [15:0]            w_s2;
    logic [18:0]            w_amp;
    logic [15:0]            w_mask_clamp;
    logic [K_W:0]           w_k_next;
    logic                   w_k_last;
    logic                   w_inner;
    logic [PHASE_BITS-1:0]  w_incr;
    logic [K_W+PHASE_BITS-1:0] w_incr_wide;
    logic [PHASE_BITS+SINE_TABLE_BITS-1:0] w_sidx_wide;
    logic [SINE_TABLE_BITS-1:0] w_sidx;
    logic signed [15:0]     w_sine_rom [SINE_LEN];
    logic                   w_accept;
    logic                   w_out_free;
    logic signed [SUM_W-1:0] w_sat_hi;
    logic signed [SUM_W-1:0] w_sat_lo;
    logic signed [31:0]     w_sat;

    for (genvar g = 0; g < SINE_LEN; g++) begin : g_rom
        assign w_sine_rom[g] = sine_entry(g, SINE_TABLE_BITS);
    end

    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    assign w_diff = $signed({1'b0, r_t_rd}) - $signed({1'b0, r_s_rd});
    assign w_s1   = $signed({3'b000, r_s_rd}) + 19'($signed(r_prod[33:16]));
    assign w_s2   = r_prod[31:16];
    assign w_amp  = r_prod[30:12];

    assign w_k_next = (K_W+1)'(r_k) + (K_W+1)'(r_stride);
    assign w_k_last = (r_k == K_W'(NUM_BINS - 1));
    assign w_inner  = (r_k != '0) && !w_k_last;

    assign w_incr_wide = {r_k, {PHASE_BITS{1'b0}}} >> FFT_LOG;
    assign w_incr      = w_incr_wide[PHASE_BITS-1:0];
    assign w_sidx_wide = {r_p_rd, {SINE_TABLE_BITS{1'b0}}};
    assign w_sidx      = w_sidx_wide[PHASE_BITS+SINE_TABLE_BITS-1 -: SINE_TABLE_BITS];

    assign w_sat_hi = $signed({{(SUM_W-32){1'b0}}, 32'h7fff_ffff});
    assign w_sat_lo = $signed({{(SUM_W-32){1'b1}}, 32'h8000_0000});
    assign w_sat    = (r_sum > w_sat_hi) ? 32'sh7fff_ffff :
                      (r_sum < w_sat_lo) ? 32'sh8000_0000 : r_sum[31:0];

    always_comb begin
        if (r_mask[15] && (r_mask[14:0] != '0)) begin
            w_mask_clamp = 16'(ONE_Q15);
        end else begin
            w_mask_clamp = r_mask;
        end
    end

    always_comb begin
        case (r_state)
            ST_F_M1: begin
                w_mul_a = $signed({1'b0, r_smooth});
                w_mul_b = 21'(w_diff);
            end
            ST_F_M2: begin
                w_mul_a = $signed({1'b0, w_s1[15:0]});
                w_mul_b = $signed({5'b0, r_decay});
            end
            ST_S_AMP: begin
                w_mul_a = $signed({1'b0, r_s_rd});
                w_mul_b = $signed({5'b0, r_gain});
            end
            ST_S_TERM: begin
                w_mul_a = 17'(r_sin);
                w_mul_b = $signed({2'b0, r_amp});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        w_t_we = 1'b0;
        w_s_we = 1'b0;
        w_p_we = 1'b0;
        w_t_wd = '0;
        w_s_wd = '0;
        w_p_wd = '0;
        case (r_state)
            ST_CLR: begin
                w_t_we = 1'b1;
                w_s_we = 1'b1;
                w_p_we = 1'b1;
            end
            ST_M_WR: begin
                w_t_we = (w_mask_clamp > r_t_rd);
                w_t_wd = w_mask_clamp;
            end
            ST_F_WR: begin
                w_t_we = 1'b1;
                w_s_we = 1'b1;
                w_s_wd = w_s2;
            end
            ST_S_CHK: begin
                w_p_we = (w_amp > 19'(r_thr));
                w_p_wd = r_p_rd + w_incr;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_t_we) begin
            mem_t[r_k] <= w_t_wd;
        end
        r_t_rd <= mem_t[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (w_s_we) begin
            mem_s[r_k] <= w_s_wd;
        end
        r_s_rd <= mem_s[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (w_p_we) begin
            mem_p[r_k] <= w_p_wd;
        end
        r_p_rd <= mem_p[r_k];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        r_sin  <= w_sine_rom[w_sidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= 16'd13107;
            r_decay  <= 16'd64225;
            r_thr    <= 16'd3;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_SMOOTH:    r_smooth <= i_cfg_wr_data;
                CFG_DECAY:     r_decay  <= i_cfg_wr_data;
                CFG_THRESHOLD: r_thr    <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_k         <= '0;
            r_gain      <= '0;
            r_active    <= '0;
            r_stride    <= 2'd1;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !((r_state == ST_DONE) && w_out_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLR: begin
                    if (w_k_last) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_mode <= i_mode;
                        case (i_mode)
                            MODE_MASK: begin
                                r_k <= K_W'(i_bin_index);
                                if (i_mask_value < 0) begin
                                    r_mask <= '0;
                                end else if (i_mask_value > 17'sd32768) begin
                                    r_mask <= 16'(ONE_Q15);
                                end else begin
                                    r_mask <= i_mask_value[15:0];
                                end
                                if (32'(i_bin_index) < 32'(NUM_BINS)) begin
                                    r_state <= ST_M_RD;
                                end
                            end
                            MODE_FRAME: begin
                                r_gain  <= i_gain;
                                r_k     <= '0;
                                r_cnt   <= '0;
                                r_state <= ST_F_RD;
                            end
                            MODE_SAMPLE: begin
                                r_k     <= K_W'(1);
                                r_sum   <= '0;
                                r_state <= ST_S_RD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_M_RD:  r_state <= ST_M_WR;
                ST_M_WR:  r_state <= ST_IDLE;
                ST_F_RD:  r_state <= ST_F_M1;
                ST_F_M1:  r_state <= ST_F_M2;
                ST_F_M2:  r_state <= ST_F_WR;
                ST_F_WR: begin
                    if (w_inner && (w_s2 > r_thr)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (w_k_last) begin
                        r_active <= r_cnt;
                        r_stride <= (32'(r_cnt) < 32'(STRIDE_LIMIT)) ? 2'd1 : 2'd2;
                        r_state  <= ST_DONE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_F_RD;
                    end
                end
                ST_S_RD:  r_state <= ST_S_AMP;
                ST_S_AMP: r_state <= ST_S_CHK;
                ST_S_CHK: begin
                    if (w_amp > 19'(r_thr)) begin
                        r_amp   <= (w_amp < 19'(MIN_AMP_Q15)) ? 19'(MIN_AMP_Q15) : w_amp;
                        r_state <= ST_S_TERM;
                    end else if (w_k_next > (K_W+1)'(NUM_BINS - 2)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_k     <= w_k_next[K_W-1:0];
                        r_state <= ST_S_RD;
                    end
                end
                ST_S_TERM: r_state <= ST_S_ACC;
                ST_S_ACC: begin
                    r_sum <= r_sum + SUM_W'($signed(r_prod[37:15]));
                    if (w_k_next > (K_W+1)'(NUM_BINS - 2)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_k     <= w_k_next[K_W-1:0];
                        r_state <= ST_S_RD;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_kind   <= (r_mode == MODE_SAMPLE);
                        r_out_sample <= (r_mode == MODE_SAMPLE) ? w_sat : '0;
                        r_out_active <= (32'(r_active) > 32'(ACTIVE_MAX)) ?
                                        9'(ACTIVE_MAX) : 9'(r_active);
                        r_out_stride <= r_stride;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_sample_value = r_out_sample;
    assign o_active_bins  = r_out_active;
    assign o_stride_used  = r_out_stride;

endmodule
